// ===== hdl/mbf_pkg.sv =====
package mbf_pkg;

  typedef enum logic [1:0] {
    FUNC_PACK   = 2'd0,
    FUNC_UNPACK = 2'd1,
    FUNC_ROUND  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] double_bits;
    logic [39:0] mbf_bits;
  } in_item_t;

  typedef struct packed {
    logic [39:0] mbf_out;
    logic [63:0] double_out;
    logic        in_range;
  } out_item_t;

  localparam logic [7:0]  MBF_EXP_MAX = 8'hFF;
  localparam logic [10:0] EXP_ADJ     = 11'd894;

  // mbf to binary64, exact
  function automatic logic [63:0] mbf_to_double(input logic [39:0] mb);
    logic [10:0] ex;
    begin
      ex = {3'b000, mb[39:32]} + EXP_ADJ;
      if (mb[39:32] == 8'h00) mbf_to_double = 64'd0;
      else mbf_to_double = {mb[31], ex, mb[30:0], 21'd0};
    end
  endfunction

  function automatic logic [39:0] mbf_saturate(input logic neg);
    mbf_saturate = {MBF_EXP_MAX, neg, 31'h7FFFFFFF};
  endfunction

endpackage

// ===== hdl/mbf_round.sv =====
// stage 1: split fields, round significand, classify
module rnd_split_stage (
  input  logic             clk,
  input  logic             valid_i,
  input  mbf_pkg::in_item_t item_i,
  output logic             valid_o,
  output logic [1:0]       func_o,
  output logic             sign_o,
  output logic [10:0]      exp_o,
  output logic [32:0]      mant_o,
  output logic             special_o,
  output logic             spec_neg_o,
  output logic             zero_o,
  output logic [39:0]      mbf_o,
  input  logic             rst_n
);
  import mbf_pkg::*;

  logic        valid_r;
  logic [1:0]  func_r;
  logic        sign_r, special_r, spec_neg_r, zero_r;
  logic [10:0] exp_r;
  logic [32:0] mant_r;
  logic [39:0] mbf_r;
  logic [53:0] sum;

  // half-up rounding of the 53-bit significand at bit 21
  assign sum = {1'b0, 1'b1, item_i.double_bits[51:0]} + 54'(1 << 20);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
    func_r     <= item_i.func;
    sign_r     <= item_i.double_bits[63];
    exp_r      <= item_i.double_bits[62:52];
    mant_r     <= sum[53:21];
    special_r  <= item_i.double_bits[62:52] == 11'h7FF;
    spec_neg_r <= item_i.double_bits[63] && item_i.double_bits[51:0] == 52'd0;
    zero_r     <= item_i.double_bits[62:52] == 11'h000;
    mbf_r      <= item_i.mbf_bits;
  end

  assign valid_o = valid_r;
  assign func_o = func_r;
  assign sign_o = sign_r;
  assign exp_o = exp_r;
  assign mant_o = mant_r;
  assign special_o = special_r;
  assign spec_neg_o = spec_neg_r;
  assign zero_o = zero_r;
  assign mbf_o = mbf_r;
endmodule

// ===== hdl/mbf_pack.sv =====
// stage 2: exponent rebias, carry-out, range checks
module rebias_stage (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  logic [1:0]  func_i,
  input  logic        sign_i,
  input  logic [10:0] exp_i,
  input  logic [32:0] mant_i,
  input  logic        special_i,
  input  logic        spec_neg_i,
  input  logic        zero_i,
  input  logic [39:0] mbf_i,
  output logic        valid_o,
  output logic [1:0]  func_o,
  output logic [39:0] packed_o,
  output logic        ok_o,
  output logic [39:0] mbf_o
);
  import mbf_pkg::*;

  logic        valid_r, ok_r, ok_nxt;
  logic [1:0]  func_r;
  logic [39:0] packed_r, packed_nxt, mbf_r;
  logic [12:0] xe;

  // xe = e - 894 (+1 on carry-out), kept signed in 13 bits
  always_comb begin
    xe = {2'b00, exp_i} - 13'd894 + {12'd0, mant_i[32]};
    ok_nxt = 1'b1;
    if (special_i) begin
      ok_nxt = 1'b0;
      packed_nxt = mbf_saturate(spec_neg_i);
    end else if (zero_i) begin
      packed_nxt = 40'd0;
    end else if (!xe[12] && xe > 13'd255) begin
      ok_nxt = 1'b0;
      packed_nxt = mbf_saturate(sign_i);
    end else if (xe[12] || xe == 13'd0) begin
      packed_nxt = 40'd0;
    end else begin
      // on carry-out the low 31 bits are zero either way
      packed_nxt = {xe[7:0], sign_i, mant_i[32] ? 31'd0 : mant_i[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
    func_r   <= func_i;
    packed_r <= packed_nxt;
    ok_r     <= ok_nxt;
    mbf_r    <= mbf_i;
  end

  assign valid_o = valid_r;
  assign func_o = func_r;
  assign packed_o = packed_r;
  assign ok_o = ok_r;
  assign mbf_o = mbf_r;
endmodule

// ===== hdl/ieee_double_mbf_converter_core.sv =====
// Converts binary64 and 40-bit MBF values. One item is taken every cycle
// (busy is always low); each result appears on out_* with out_valid high
// after the three register stages of round, pack and output select. The
// receiver cannot stall, so every result must be taken in the cycle it is
// shown.
module ieee_double_mbf_converter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mbf_pkg::in_item_t  in_item,
  output logic              out_valid,
  output mbf_pkg::out_item_t out_item
);
  import mbf_pkg::*;

  logic        v1, v2, sign1, spec1, specn1, zero1, ok2;
  logic [1:0]  func1, func2;
  logic [10:0] exp1;
  logic [32:0] mant1;
  logic [39:0] mbf1, mbf2, pk2;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  assign busy = 1'b0;

  rnd_split_stage u_round (
    .clk(clk), .valid_i(start), .item_i(in_item), .valid_o(v1), .func_o(func1),
    .sign_o(sign1), .exp_o(exp1), .mant_o(mant1), .special_o(spec1),
    .spec_neg_o(specn1), .zero_o(zero1), .mbf_o(mbf1), .rst_n(rst_n)
  );

  rebias_stage u_pack (
    .clk(clk), .rst_n(rst_n), .valid_i(v1), .func_i(func1), .sign_i(sign1),
    .exp_i(exp1), .mant_i(mant1), .special_i(spec1), .spec_neg_i(specn1),
    .zero_i(zero1), .mbf_i(mbf1), .valid_o(v2), .func_o(func2),
    .packed_o(pk2), .ok_o(ok2), .mbf_o(mbf2)
  );

  // output select per function
  always_comb begin
    out_nxt = '0;
    out_nxt.in_range = 1'b1;
    case (func_t'(func2))
      FUNC_PACK: begin
        out_nxt.mbf_out = pk2;
        out_nxt.in_range = ok2;
      end
      FUNC_UNPACK: out_nxt.double_out = mbf_to_double(mbf2);
      FUNC_ROUND: begin
        out_nxt.mbf_out = pk2;
        out_nxt.double_out = mbf_to_double(pk2);
        out_nxt.in_range = ok2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= v2;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // a transfer appears after the round, pack and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ##3 (out_valid == $past(start, 3))) else $error("latency broken");
  // unpack never flags out of range
  a_unpack_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (v2 && func2 == FUNC_UNPACK) |=> out_item.in_range) else $error("unpack range");
  // saturation always carries the max exponent
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.in_range) |-> out_item.mbf_out[39:32] == MBF_EXP_MAX)
    else $error("saturation exponent");
endmodule
